[hdl/msegc_pkg.sv]
// Shared types, microcode encodings and constant tables of the
// multiplexed seven-segment controller. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msegc_pkg;

    localparam int NUM_DIGITS_DEF = 4;

    // Operation codes of an input item
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_WRITE  = 3'd1;
    localparam logic [2:0] OP_CLEAR  = 3'd2;
    localparam logic [2:0] OP_DOT_ON = 3'd3;
    localparam logic [2:0] OP_DOT_OFF = 3'd4;
    localparam logic [2:0] OP_DOT_TGL = 3'd5;

    // Reciprocal of ten for a 32-bit quotient: q = (t * RECIP10) >> RECIP_SHIFT
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          MAX_LEN     = 10;

    // Microprogram addresses
    typedef logic [3:0] t_pc;
    localparam t_pc PC_IDLE     = 4'd0;
    localparam t_pc PC_TICK     = 4'd1;
    localparam t_pc PC_CLEAR    = 4'd2;
    localparam t_pc PC_DOT      = 4'd3;
    localparam t_pc PC_LEN      = 4'd4;
    localparam t_pc PC_PLACE    = 4'd5;
    localparam t_pc PC_DIV_MUL  = 4'd6;
    localparam t_pc PC_DIV_PUT  = 4'd7;
    localparam t_pc PC_FILL     = 4'd8;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_EMIT,
        ACT_CLEAR,
        ACT_DOT,
        ACT_LEN,
        ACT_PLACE,
        ACT_DIV_MUL,
        ACT_DIV_PUT,
        ACT_FILL
    } t_act;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_DISPATCH,
        COND_OUT_BUSY,
        COND_LEN_MORE,
        COND_Q_NONZERO
    } t_cond;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_pc   next_t;
        t_pc   next_f;
    } t_uword;

    // Sequencer to datapath
    typedef struct packed {
        t_act act;
        logic in_ready;
    } t_ctrl;

    // Datapath to sequencer
    typedef struct packed {
        logic       accept;
        logic [2:0] opcode;
        logic       out_busy;
        logic       len_more;
        logic       q_nonzero;
    } t_stat;

    // gfedcba pattern of one decimal digit, blank for non-decimal codes
    function automatic logic [7:0] seg_code(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0: s = 8'h3F;
            4'd1: s = 8'h06;
            4'd2: s = 8'h5B;
            4'd3: s = 8'h4F;
            4'd4: s = 8'h66;
            4'd5: s = 8'h6D;
            4'd6: s = 8'h7D;
            4'd7: s = 8'h07;
            4'd8: s = 8'h7F;
            4'd9: s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // Ten to the power k, for k from one to nine
    function automatic logic [31:0] pow10(input logic [3:0] k);
        logic [31:0] p;
        case (k)
            4'd1: p = 32'd10;
            4'd2: p = 32'd100;
            4'd3: p = 32'd1000;
            4'd4: p = 32'd10000;
            4'd5: p = 32'd100000;
            4'd6: p = 32'd1000000;
            4'd7: p = 32'd10000000;
            4'd8: p = 32'd100000000;
            4'd9: p = 32'd1000000000;
            default: p = 32'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

[hdl/msegc_seq.sv]
// Microcode sequencer: program ROM, step counter and jump logic.
// Depends on msegc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msegc_seq (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  msegc_pkg::t_stat      i_stat,
    output msegc_pkg::t_ctrl      o_ctrl
);

    function automatic msegc_pkg::t_uword rom(input msegc_pkg::t_pc pc);
        msegc_pkg::t_uword w;
        case (pc)
            msegc_pkg::PC_IDLE:
                w = '{msegc_pkg::ACT_LOAD, msegc_pkg::COND_DISPATCH,
                      msegc_pkg::PC_IDLE, msegc_pkg::PC_IDLE};
            msegc_pkg::PC_TICK:
                w = '{msegc_pkg::ACT_EMIT, msegc_pkg::COND_OUT_BUSY,
                      msegc_pkg::PC_TICK, msegc_pkg::PC_IDLE};
            msegc_pkg::PC_CLEAR:
                w = '{msegc_pkg::ACT_CLEAR, msegc_pkg::COND_ALWAYS,
                      msegc_pkg::PC_IDLE, msegc_pkg::PC_IDLE};
            msegc_pkg::PC_DOT:
                w = '{msegc_pkg::ACT_DOT, msegc_pkg::COND_ALWAYS,
                      msegc_pkg::PC_IDLE, msegc_pkg::PC_IDLE};
            msegc_pkg::PC_LEN:
                w = '{msegc_pkg::ACT_LEN, msegc_pkg::COND_LEN_MORE,
                      msegc_pkg::PC_LEN, msegc_pkg::PC_PLACE};
            msegc_pkg::PC_PLACE:
                w = '{msegc_pkg::ACT_PLACE, msegc_pkg::COND_ALWAYS,
                      msegc_pkg::PC_DIV_MUL, msegc_pkg::PC_DIV_MUL};
            msegc_pkg::PC_DIV_MUL:
                w = '{msegc_pkg::ACT_DIV_MUL, msegc_pkg::COND_ALWAYS,
                      msegc_pkg::PC_DIV_PUT, msegc_pkg::PC_DIV_PUT};
            msegc_pkg::PC_DIV_PUT:
                w = '{msegc_pkg::ACT_DIV_PUT, msegc_pkg::COND_Q_NONZERO,
                      msegc_pkg::PC_DIV_MUL, msegc_pkg::PC_FILL};
            msegc_pkg::PC_FILL:
                w = '{msegc_pkg::ACT_FILL, msegc_pkg::COND_ALWAYS,
                      msegc_pkg::PC_IDLE, msegc_pkg::PC_IDLE};
            default:
                w = '{msegc_pkg::ACT_NONE, msegc_pkg::COND_ALWAYS,
                      msegc_pkg::PC_IDLE, msegc_pkg::PC_IDLE};
        endcase
        return w;
    endfunction

    function automatic msegc_pkg::t_pc dispatch(input logic [2:0] op);
        msegc_pkg::t_pc p;
        case (op)
            msegc_pkg::OP_TICK:    p = msegc_pkg::PC_TICK;
            msegc_pkg::OP_WRITE:   p = msegc_pkg::PC_LEN;
            msegc_pkg::OP_CLEAR:   p = msegc_pkg::PC_CLEAR;
            msegc_pkg::OP_DOT_ON:  p = msegc_pkg::PC_DOT;
            msegc_pkg::OP_DOT_OFF: p = msegc_pkg::PC_DOT;
            msegc_pkg::OP_DOT_TGL: p = msegc_pkg::PC_DOT;
            default:               p = msegc_pkg::PC_IDLE;
        endcase
        return p;
    endfunction

    msegc_pkg::t_pc    r_pc;
    msegc_pkg::t_pc    n_pc;
    msegc_pkg::t_uword w_word;

    assign w_word          = rom(r_pc);
    assign o_ctrl.act      = w_word.act;
    assign o_ctrl.in_ready = (r_pc == msegc_pkg::PC_IDLE);

    always_comb begin
        case (w_word.cond)
            msegc_pkg::COND_ALWAYS:
                n_pc = w_word.next_t;
            msegc_pkg::COND_DISPATCH:
                n_pc = i_stat.accept ? dispatch(i_stat.opcode) : r_pc;
            msegc_pkg::COND_OUT_BUSY:
                n_pc = i_stat.out_busy ? w_word.next_t : w_word.next_f;
            msegc_pkg::COND_LEN_MORE:
                n_pc = i_stat.len_more ? w_word.next_t : w_word.next_f;
            msegc_pkg::COND_Q_NONZERO:
                n_pc = i_stat.q_nonzero ? w_word.next_t : w_word.next_f;
            default:
                n_pc = msegc_pkg::PC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= msegc_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

[hdl/multiplexed_seven_segment_controller.sv]
// Tick: after the transfer, the TICK step registers the scanned digit's outputs and
// waits in place while the previous result has not been taken.
// Write number: a digit-count loop, a placement step, then a multiply step and a put step
// of the datapath's divide-by-ten for each digit of the magnitude, then a fill step.
// Clear and dot operations return to idle after their step. One item at a time.
// Synchronous active-low reset clears digits, dots, scan index, polarity and output valid.
`timescale 1ns / 1ps
`default_nettype none

module multiplexed_seven_segment_controller #(
    parameter int NUM_DIGITS = msegc_pkg::NUM_DIGITS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire        [2:0]  i_opcode,
    input  wire signed [31:0] i_value,
    input  wire signed [7:0]  i_start_position,
    input  wire signed [7:0]  i_min_digits,
    input  wire        [3:0]  i_dot_number,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic       [7:0]  o_segments,
    output logic              o_dot_drive,
    output logic       [3:0]  o_digit_enable,
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire               i_cfg_common_anode
);

    localparam int IW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    msegc_pkg::t_ctrl w_ctrl;
    msegc_pkg::t_stat w_stat;

    logic [3:0]        r_digit [NUM_DIGITS];
    logic [NUM_DIGITS-1:0] r_dots;
    logic [IW-1:0]     r_scan;
    logic              r_ca;
    logic              r_out_valid;
    logic [7:0]        r_segments;
    logic              r_dot_drive;
    logic [3:0]        r_enable;

    logic [2:0]        r_op;
    logic [3:0]        r_dn;
    logic              r_neg;
    logic [31:0]       r_mag;
    logic [7:0]        r_start;
    logic [7:0]        r_mind;
    logic [3:0]        r_len;
    logic [7:0]        r_pad;
    logic [7:0]        r_pos;
    logic [28:0]       r_q;

    logic              w_accept;
    logic              w_out_busy;
    logic [63:0]       w_prod;
    logic [3:0]        w_q10_lo;
    logic [3:0]        w_rem;
    logic [7:0]        w_pad_raw;
    logic [7:0]        w_pad;
    logic [7:0]        w_pos;
    logic [7:0]        w_scan8;
    logic [3:0]        w_cur_digit;
    logic              w_cur_dot;
    logic [7:0]        w_seg;
    logic [3:0]        w_enable;

    msegc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    assign o_in_ready     = w_ctrl.in_ready;
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_segments     = r_segments;
    assign o_dot_drive    = r_dot_drive;
    assign o_digit_enable = r_enable;

    assign w_accept   = i_in_valid & w_ctrl.in_ready;
    assign w_out_busy = r_out_valid & ~i_out_ready;

    assign w_stat.accept    = w_accept;
    assign w_stat.opcode    = i_opcode;
    assign w_stat.out_busy  = w_out_busy;
    assign w_stat.len_more  = (r_len < 4'(msegc_pkg::MAX_LEN)) &&
                              (r_mag >= msegc_pkg::pow10(r_len));
    assign w_stat.q_nonzero = (r_q != '0);

    // Divide by ten through the reciprocal; remainder from the low bits only
    assign w_prod   = 64'(r_mag) * 64'(msegc_pkg::RECIP10);
    assign w_q10_lo = {r_q[0], 3'b000} + {r_q[2:0], 1'b0};
    assign w_rem    = r_mag[3:0] - w_q10_lo;

    // Field placement: zero pad clamped at zero, last digit position in 8-bit wrap
    assign w_pad_raw = r_mind - {4'b0000, r_len};
    assign w_pad     = w_pad_raw[7] ? 8'd0 : w_pad_raw;
    assign w_pos     = {7'b0, r_neg} + {4'b0000, r_len} + r_start + w_pad - 8'd2;

    // Scanned position
    assign w_scan8     = 8'(r_scan);
    assign w_cur_digit = r_digit[r_scan];
    assign w_cur_dot   = r_dots[r_scan];
    assign w_seg       = msegc_pkg::seg_code(w_cur_digit);

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_enable[j] = (w_scan8 == 8'(j));
        end
    end

    // Operand capture and arithmetic registers
    always_ff @(posedge i_clk) begin
        if (w_ctrl.act == msegc_pkg::ACT_LOAD && w_accept) begin
            r_op    <= i_opcode;
            r_dn    <= i_dot_number;
            r_neg   <= i_value[31];
            r_mag   <= i_value[31] ? (32'd0 - i_value) : i_value;
            r_start <= i_start_position;
            r_mind  <= i_min_digits;
            r_len   <= 4'd1;
        end
        case (w_ctrl.act)
            msegc_pkg::ACT_LEN: begin
                if (w_stat.len_more) begin
                    r_len <= r_len + 4'd1;
                end
            end
            msegc_pkg::ACT_PLACE: begin
                r_pad <= w_pad;
                r_pos <= w_pos;
            end
            msegc_pkg::ACT_DIV_MUL: begin
                r_q <= w_prod[63:msegc_pkg::RECIP_SHIFT];
            end
            msegc_pkg::ACT_DIV_PUT: begin
                r_mag <= 32'(r_q);
                r_pos <= r_pos - 8'd1;
            end
            default: begin
            end
        endcase
    end

    // Digit store, dot mask, scan index and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_digit[i] <= 4'd0;
            end
            r_dots      <= '0;
            r_scan      <= '0;
            r_ca        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_ca <= i_cfg_common_anode;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (w_ctrl.act)
                msegc_pkg::ACT_EMIT: begin
                    if (!w_out_busy) begin
                        r_out_valid <= 1'b1;
                        r_segments  <= r_ca ? ~w_seg : w_seg;
                        r_dot_drive <= w_cur_dot ^ r_ca;
                        r_enable    <= w_enable;
                        r_scan      <= (r_scan == IW'(NUM_DIGITS - 1)) ? '0 : r_scan + 1'b1;
                    end
                end
                msegc_pkg::ACT_CLEAR: begin
                    for (int i = 0; i < NUM_DIGITS; i++) begin
                        r_digit[i] <= 4'd0;
                    end
                end
                msegc_pkg::ACT_DOT: begin
                    for (int i = 0; i < NUM_DIGITS; i++) begin
                        if (r_dn == 4'(i + 1)) begin
                            case (r_op)
                                msegc_pkg::OP_DOT_ON:  r_dots[i] <= 1'b1;
                                msegc_pkg::OP_DOT_OFF: r_dots[i] <= 1'b0;
                                msegc_pkg::OP_DOT_TGL: r_dots[i] <= ~r_dots[i];
                                default:               r_dots[i] <= r_dots[i];
                            endcase
                        end
                    end
                end
                msegc_pkg::ACT_DIV_PUT: begin
                    for (int i = 0; i < NUM_DIGITS; i++) begin
                        if (r_pos == 8'(i)) begin
                            r_digit[i] <= w_rem;
                        end
                    end
                end
                msegc_pkg::ACT_FILL: begin
                    // zero every position still inside the padding run
                    for (int i = 0; i < NUM_DIGITS; i++) begin
                        if (8'(r_pos - 8'(i)) < r_pad) begin
                            r_digit[i] <= 4'd0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire
